### sv/ebd_pkg.sv
// Package for the EAST box decoder: shared types, CORDIC table and format constants.
// Used by the front, queue, back and top-level modules; depends on nothing.
package ebd_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam logic signed [14:0] ANGLE_LIMIT = 15'sd12868;
	localparam logic [15:0] DEG_SCALE_Q16 = 16'd58671;
	localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
	localparam logic [15:0] THRESH_RESET = 16'd32768;

	// Arctangent table, Q16 radians.
	function automatic logic signed [17:0] atan_q16(input logic [3:0] idx);
		logic signed [17:0] r;
		begin
			unique case (idx)
				4'd0: r = 18'sd51472;
				4'd1: r = 18'sd30386;
				4'd2: r = 18'sd16055;
				4'd3: r = 18'sd8150;
				4'd4: r = 18'sd4091;
				4'd5: r = 18'sd2047;
				4'd6: r = 18'sd1024;
				4'd7: r = 18'sd512;
				4'd8: r = 18'sd256;
				4'd9: r = 18'sd128;
				4'd10: r = 18'sd64;
				4'd11: r = 18'sd32;
				4'd12: r = 18'sd16;
				4'd13: r = 18'sd8;
				4'd14: r = 18'sd4;
				default: r = 18'sd2;
			endcase
			return r;
		end
	endfunction

	// One accepted cell as it leaves the front part.
	typedef struct packed {
		logic [7:0] col;
		logic [7:0] row;
		logic [15:0] score;
		logic [15:0] dt;
		logic [15:0] dr;
		logic [15:0] db;
		logic [15:0] dl;
		logic signed [14:0] ang;
	} ebd_cell_t;

endpackage

### sv/ebd_front.sv
// Front part of the EAST box decoder: score and map range check, angle clamp.
// Depends on ebd_pkg.
module ebd_front import ebd_pkg::*; #(
	parameter int MAP_DIM_MAX = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_take,
	input  logic [15:0] thresh,
	input  ebd_cell_t in_cell,
	output logic cell_valid_s1,
	output ebd_cell_t cell_s1
);

	logic keep;
	logic signed [14:0] ang_c;
	ebd_cell_t cell_c;

	// Drop weak cells and cells outside the map; clamp the angle.
	always_comb begin
		keep = (in_cell.score >= thresh) &&
			(32'(in_cell.col) < 32'(MAP_DIM_MAX)) &&
			(32'(in_cell.row) < 32'(MAP_DIM_MAX));
		ang_c = in_cell.ang;
		if (in_cell.ang > ANGLE_LIMIT) ang_c = ANGLE_LIMIT;
		if (in_cell.ang < -ANGLE_LIMIT) ang_c = -ANGLE_LIMIT;
		cell_c = in_cell;
		cell_c.ang = ang_c;
	end

	// Advance the classified cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_s1 <= 1'b0;
		end else begin
			cell_valid_s1 <= in_take && keep;
		end
	end

	always_ff @(posedge clk) begin
		cell_s1 <= cell_c;
	end

endmodule

### sv/ebd_queue.sv
// Short queue between front and back of the EAST box decoder.
// Depends on ebd_pkg.
module ebd_queue import ebd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ebd_cell_t push_cell,
	input  logic pop,
	output logic not_empty,
	output logic almost_full,
	output ebd_cell_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	ebd_cell_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign not_empty = cnt_q != '0;
	assign almost_full = cnt_q >= (AW+1)'(DEPTH - 2);
	assign head = mem_q[rp_q];

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_cell;
	end

endmodule

### sv/ebd_back.sv
// Back part of the EAST box decoder: pipelined CORDIC, rotation products, centre.
// Depends on ebd_pkg.
module ebd_back import ebd_pkg::*; #(
	parameter int CELL_STRIDE = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  ebd_cell_t in_cell,
	output logic out_valid,
	output logic signed [17:0] center_x,
	output logic signed [17:0] center_y,
	output logic [16:0] box_width,
	output logic [16:0] box_height,
	output logic signed [14:0] angle_deg,
	output logic [15:0] confidence
);

	localparam int N = CORDIC_STEPS;

	// CORDIC pipeline registers, one stage per step.
	logic vld_q [N+1];
	ebd_cell_t cel_q [N+1];
	logic signed [32:0] x_q [N+1];
	logic signed [32:0] y_q [N+1];
	logic signed [18:0] z_q [N+1];

	always_comb begin
		vld_q[0] = in_valid;
		cel_q[0] = in_cell;
		x_q[0] = 33'(CORDIC_GAIN_Q30);
		y_q[0] = '0;
		z_q[0] = 19'(in_cell.ang) <<< 3;
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[i+1] <= 1'b0;
			else vld_q[i+1] <= vld_q[i];
		end
		always_ff @(posedge clk) begin
			cel_q[i+1] <= cel_q[i];
			if (!z_q[i][18]) begin
				x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] - 19'(atan_q16(4'(i)));
			end else begin
				x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] + 19'(atan_q16(4'(i)));
			end
		end
	end

	// Round to Q16, form sums and degrees.
	logic signed [33:0] xr, yr;
	assign xr = 34'(x_q[N]) + 34'sd8192;
	assign yr = 34'(y_q[N]) + 34'sd8192;

	logic vld_s1;
	logic signed [18:0] cs_s1, sn_s1;
	ebd_cell_t c_s1;
	logic [16:0] w_s1, h_s1;
	logic [14:0] mag_a;
	logic [30:0] degp;
	always_comb begin
		mag_a = cel_q[N].ang[14] ? 15'(-cel_q[N].ang) : 15'(cel_q[N].ang);
		degp = 31'(mag_a) * 31'(DEG_SCALE_Q16) + 31'd32768;
	end
	logic signed [14:0] deg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= vld_q[N];
	end
	always_ff @(posedge clk) begin
		cs_s1 <= 19'(xr >>> 14);
		sn_s1 <= 19'(yr >>> 14);
		c_s1 <= cel_q[N];
		w_s1 <= 17'(cel_q[N].dr) + 17'(cel_q[N].dl);
		h_s1 <= 17'(cel_q[N].dt) + 17'(cel_q[N].db);
		deg_s1 <= cel_q[N].ang[14] ? 15'(degp[30:16]) : -15'(degp[30:16]);
	end

	// Products, one multiplier each.
	logic vld_s2;
	logic signed [37:0] p_cdr, p_sdb, p_cdb, p_sdr, p_sh, p_cw, p_ch, p_sw;
	ebd_cell_t c_s2;
	logic [16:0] w_s2, h_s2;
	logic signed [14:0] deg_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		p_cdr <= 38'(cs_s1) * 38'(signed'({1'b0, c_s1.dr}));
		p_sdb <= 38'(sn_s1) * 38'(signed'({1'b0, c_s1.db}));
		p_cdb <= 38'(cs_s1) * 38'(signed'({1'b0, c_s1.db}));
		p_sdr <= 38'(sn_s1) * 38'(signed'({1'b0, c_s1.dr}));
		p_sh <= 38'(sn_s1) * 38'(signed'({1'b0, h_s1}));
		p_cw <= 38'(cs_s1) * 38'(signed'({1'b0, w_s1}));
		p_ch <= 38'(cs_s1) * 38'(signed'({1'b0, h_s1}));
		p_sw <= 38'(sn_s1) * 38'(signed'({1'b0, w_s1}));
		c_s2 <= c_s1;
		w_s2 <= w_s1;
		h_s2 <= h_s1;
		deg_s2 <= deg_s1;
	end

	// Sum, round and saturate.
	logic signed [47:0] bx, by, tx, ty, rx, ry;
	always_comb begin
		bx = 48'(c_s2.col) * 48'(2 * CELL_STRIDE) <<< 20;
		by = 48'(c_s2.row) * 48'(2 * CELL_STRIDE) <<< 20;
		tx = bx + 2 * (48'(p_cdr) + 48'(p_sdb)) - 48'(p_sh) - 48'(p_cw) + 48'sd65536;
		ty = by + 2 * (48'(p_cdb) - 48'(p_sdr)) - 48'(p_ch) + 48'(p_sw) + 48'sd65536;
		rx = tx >>> 17;
		ry = ty >>> 17;
	end

	function automatic logic signed [17:0] sat18(input logic signed [47:0] v);
		logic signed [17:0] r;
		begin
			if (v > 48'sd131071) r = 18'sd131071;
			else if (v < -48'sd131072) r = -18'sd131072;
			else r = 18'(v);
			return r;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= vld_s2;
	end
	always_ff @(posedge clk) begin
		center_x <= sat18(rx);
		center_y <= sat18(ry);
		box_width <= w_s2;
		box_height <= h_s2;
		angle_deg <= deg_s2;
		confidence <= c_s2.score;
	end

endmodule

### sv/east_box_decode_core.sv
// Top level of the EAST box decoder: front classifier, queue, back pipeline.
// Depends on ebd_pkg, ebd_front, ebd_queue, ebd_back.
//
// One cell is taken per cycle while busy is low; busy never rises because the
// receiver cannot stall and the back pipeline takes one cell per cycle from the
// queue. A kept cell gives its box after passing the front stage, the queue,
// 16 CORDIC stages, rounding, product and output stages; a cell scoring below
// the threshold or outside the map gives no strobe. Write the threshold only
// while no cell is in flight.
module east_box_decode_core import ebd_pkg::*; #(
	parameter int MAP_DIM_MAX = 256,
	parameter int CELL_STRIDE = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [7:0] cell_col,
	input  logic [7:0] cell_row,
	input  logic [15:0] score,
	input  logic [15:0] dist_top,
	input  logic [15:0] dist_right,
	input  logic [15:0] dist_bottom,
	input  logic [15:0] dist_left,
	input  logic signed [14:0] angle_rad,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data,
	output logic done,
	output logic signed [17:0] center_x,
	output logic signed [17:0] center_y,
	output logic [16:0] box_width,
	output logic [16:0] box_height,
	output logic signed [14:0] angle_deg,
	output logic [15:0] confidence
);

	logic [15:0] thresh_q;
	ebd_cell_t in_cell, cell_s1, head;
	logic cell_valid_s1, not_empty, almost_full;

	assign cfg_ready = 1'b1;
	assign busy = almost_full;

	// Hold the threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thresh_q <= THRESH_RESET;
		else if (cfg_valid && cfg_ready) thresh_q <= cfg_data;
	end

	always_comb begin
		in_cell.col = cell_col;
		in_cell.row = cell_row;
		in_cell.score = score;
		in_cell.dt = dist_top;
		in_cell.dr = dist_right;
		in_cell.db = dist_bottom;
		in_cell.dl = dist_left;
		in_cell.ang = angle_rad;
	end

	ebd_front #(.MAP_DIM_MAX(MAP_DIM_MAX)) u_front (
		.clk(clk), .arst_n(arst_n), .in_take(start && !busy), .thresh(thresh_q),
		.in_cell(in_cell), .cell_valid_s1(cell_valid_s1), .cell_s1(cell_s1)
	);

	ebd_queue #(.DEPTH(4)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(cell_valid_s1), .push_cell(cell_s1),
		.pop(not_empty), .not_empty(not_empty), .almost_full(almost_full), .head(head)
	);

	ebd_back #(.CELL_STRIDE(CELL_STRIDE)) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(not_empty), .in_cell(head),
		.out_valid(done), .center_x(center_x), .center_y(center_y),
		.box_width(box_width), .box_height(box_height), .angle_deg(angle_deg),
		.confidence(confidence)
	);

endmodule
